FILE: src/pxfec_pkg.sv
package pxfec_pkg;

  // Packet geometry
  localparam int unsigned PAYLOAD_BYTES = 160;
  localparam int unsigned PKT_BYTES     = 4 + PAYLOAD_BYTES;
  localparam int unsigned PKT_WORDS     = (PKT_BYTES + 7) / 8;
  localparam int unsigned LAST_BYTES    = ((PKT_BYTES % 8) == 0) ? 8 : (PKT_BYTES % 8);
  localparam int unsigned ADDR_W        = $clog2(PKT_WORDS);
  localparam int unsigned CNT_W         = $clog2(PKT_WORDS + 1);

  localparam logic [31:0] PARITY_FLAG = 32'h8000_0000;
  localparam logic [3:0]  FULL_CNT    = 4'd8;
  localparam logic [3:0]  LAST_CNT    = 4'(LAST_BYTES);
  // Keep the valid leading bytes of the final packet word
  localparam logic [63:0] LAST_MASK   = ~64'd0 << (8 * (8 - LAST_BYTES));

  // Buffer read request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  // Sideband that travels with a buffer read
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              par;
    logic              copy;
    logic              first;
    logic              last;
    logic              run_last;
  } rd_tag_t;

  // One formatted output word
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        par;
    logic        pend;
    logic        run_last;
  } res_t;

endpackage

FILE: src/pxfec_buf.sv
module pxfec_buf (
  input  logic                          clk_i,
  input  logic                          cur_we_i,
  input  logic [pxfec_pkg::ADDR_W-1:0]  cur_waddr_i,
  input  logic [63:0]                   cur_wdata_i,
  input  pxfec_pkg::rd_req_t            rd_req_i,
  input  logic                          ret_valid_i,
  input  pxfec_pkg::rd_tag_t            ret_tag_i,
  output logic [63:0]                   cur_rdata_o,
  output logic [63:0]                   sto_rdata_o
);

  logic [63:0] cur_mem [pxfec_pkg::PKT_WORDS];
  logic [63:0] sto_mem [pxfec_pkg::PKT_WORDS];
  logic [63:0] cur_rdata_q;
  logic [63:0] sto_rdata_q;

  // Current datagram buffer: input writes, emission reads
  always_ff @(posedge clk_i) begin
    if (cur_we_i) begin
      cur_mem[cur_waddr_i] <= cur_wdata_i;
    end
    if (rd_req_i.en) begin
      cur_rdata_q <= cur_mem[rd_req_i.addr];
    end
  end

  // Stored first half: copy each returned word of an even packet
  always_ff @(posedge clk_i) begin
    if (ret_valid_i && ret_tag_i.copy) begin
      sto_mem[ret_tag_i.addr] <= cur_rdata_q;
    end
    if (rd_req_i.en) begin
      sto_rdata_q <= sto_mem[rd_req_i.addr];
    end
  end

  assign cur_rdata_o = cur_rdata_q;
  assign sto_rdata_o = sto_rdata_q;

endmodule

FILE: src/pxfec_ctrl.sv
module pxfec_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [63:0]                   in_data_i,
  input  logic [3:0]                    in_bytes_i,
  input  logic                          in_end_i,
  output logic                          in_ready_o,
  output logic                          cur_we_o,
  output logic [pxfec_pkg::ADDR_W-1:0]  cur_waddr_o,
  output logic [63:0]                   cur_wdata_o,
  output pxfec_pkg::rd_req_t            rd_req_o,
  input  logic                          issue_ok_i,
  output logic                          ret_valid_o,
  output pxfec_pkg::rd_tag_t            ret_tag_o,
  output logic [31:0]                   par_seq_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FWD  = 2'd1;
  localparam logic [1:0] ST_PAR  = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [pxfec_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [pxfec_pkg::ADDR_W-1:0]   idx_q, idx_d;
  logic                           copy_q, copy_d;
  logic                           par_q, par_d;
  logic                           pending_q, pending_d;
  logic [31:0]                    stored_seq_q, stored_seq_d;
  logic [31:0]                    seq_q;
  logic                           ret_valid_q;
  pxfec_pkg::rd_tag_t             ret_tag_q, tag_d;

  logic       accept;
  logic       room;
  logic       long_enough;
  logic       last_idx;
  logic       issue;
  logic [3:0] nb_eff;

  // Input side
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign nb_eff      = (!in_end_i || (in_bytes_i > pxfec_pkg::FULL_CNT)) ? pxfec_pkg::FULL_CNT
                                                                         : in_bytes_i;
  assign room        = (cnt_q < pxfec_pkg::CNT_W'(pxfec_pkg::PKT_WORDS));
  assign long_enough = !room ||
                       ((cnt_q == pxfec_pkg::CNT_W'(pxfec_pkg::PKT_WORDS - 1)) &&
                        (nb_eff >= pxfec_pkg::LAST_CNT));

  assign cur_we_o    = accept && room;
  assign cur_waddr_o = cnt_q[pxfec_pkg::ADDR_W-1:0];
  assign cur_wdata_o = in_data_i;

  // Read issue side
  assign last_idx      = (idx_q == pxfec_pkg::ADDR_W'(pxfec_pkg::PKT_WORDS - 1));
  assign issue         = ((state_q == ST_FWD) || (state_q == ST_PAR)) && issue_ok_i;
  assign rd_req_o.en   = issue;
  assign rd_req_o.addr = idx_q;

  assign tag_d.addr     = idx_q;
  assign tag_d.par      = (state_q == ST_PAR);
  assign tag_d.copy     = (state_q == ST_FWD) && copy_q;
  assign tag_d.first    = (idx_q == '0);
  assign tag_d.last     = last_idx;
  assign tag_d.run_last = last_idx && ((state_q == ST_PAR) || !par_q);

  assign ret_valid_o = ret_valid_q;
  assign ret_tag_o   = ret_tag_q;
  assign par_seq_o   = stored_seq_q | pxfec_pkg::PARITY_FLAG;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    copy_d       = copy_q;
    par_d        = par_q;
    pending_d    = pending_q;
    stored_seq_d = stored_seq_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (room) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (in_end_i) begin
            cnt_d = '0;
            if (long_enough) begin
              state_d = ST_FWD;
              idx_d   = '0;
              copy_d  = !seq_q[0];
              par_d   = seq_q[0] && pending_q && (seq_q == stored_seq_q + 32'd1);
              if (!seq_q[0]) begin
                stored_seq_d = seq_q;
                pending_d    = 1'b1;
              end else if (pending_q && (seq_q == stored_seq_q + 32'd1)) begin
                pending_d = 1'b0;
              end
            end
          end
        end
      end
      ST_FWD: begin
        if (issue) begin
          if (last_idx) begin
            idx_d   = '0;
            state_d = par_q ? ST_PAR : ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_PAR: begin
        if (issue) begin
          if (last_idx) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      idx_q        <= '0;
      copy_q       <= 1'b0;
      par_q        <= 1'b0;
      pending_q    <= 1'b0;
      stored_seq_q <= '0;
      ret_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      copy_q       <= copy_d;
      par_q        <= par_d;
      pending_q    <= pending_d;
      stored_seq_q <= stored_seq_d;
      ret_valid_q  <= issue;
    end
  end

  // Capture sequence number from the first word; hold read sideband
  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q == '0)) begin
      seq_q <= in_data_i[63:32];
    end
    if (issue) begin
      ret_tag_q <= tag_d;
    end
  end

endmodule

FILE: src/pxfec_out.sv
module pxfec_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ret_valid_i,
  input  pxfec_pkg::rd_tag_t ret_tag_i,
  input  logic [63:0]        cur_rdata_i,
  input  logic [63:0]        sto_rdata_i,
  input  logic [31:0]        par_seq_i,
  input  logic               out_ready_i,
  output logic               issue_ok_o,
  output pxfec_pkg::res_t    out_res_o,
  output logic               out_valid_o
);

  pxfec_pkg::res_t res;
  pxfec_pkg::res_t out_q, out_d;
  pxfec_pkg::res_t skid_q, skid_d;
  logic            out_v_q, out_v_d;
  logic            skid_v_q, skid_v_d;
  logic            pop;
  logic [1:0]      occ;
  logic [63:0]     word;

  // Format the returned word
  always_comb begin
    word = cur_rdata_i ^ (ret_tag_i.par ? sto_rdata_i : 64'd0);
    if (ret_tag_i.par && ret_tag_i.first) begin
      word[63:32] = par_seq_i;
    end
    if (ret_tag_i.last) begin
      word = word & pxfec_pkg::LAST_MASK;
    end
    res.data     = word;
    res.nbytes   = ret_tag_i.last ? pxfec_pkg::LAST_CNT : pxfec_pkg::FULL_CNT;
    res.par      = ret_tag_i.par;
    res.pend     = ret_tag_i.last;
    res.run_last = ret_tag_i.run_last;
  end

  // Credit: output and skid slots against words in flight
  assign pop        = out_v_q && out_ready_i;
  assign occ        = 2'(out_v_q) + 2'(skid_v_q) + 2'(ret_valid_i);
  assign issue_ok_o = ((occ - 2'(pop)) < 2'd2);

  // Output register with skid stage
  always_comb begin
    out_d    = out_q;
    skid_d   = skid_q;
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_d   = res;
        skid_v_d = ret_valid_i;
      end else begin
        out_d   = res;
        out_v_d = ret_valid_i;
      end
    end else if (ret_valid_i) begin
      skid_d   = res;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_res_o   = out_q;
  assign out_valid_o = out_v_q;

endmodule

FILE: src/pairwise_xor_parity_fec_encoder_top.sv
// Pairwise XOR parity encoder for fixed-size datagrams.
// Input stream (s_axis): one 64-bit big-endian datagram word per transfer; tlast marks
// the final word, whose byte count sits in tdata[67:64]. Words are taken one per cycle
// while the block is collecting. The first 164 bytes (sequence number and payload) are
// kept in a 21-word buffer memory; shorter datagrams are dropped at their final word.
// Output stream (m_axis): the forwarded packet (21 words) and, after an odd sequence
// number that follows a stored even one, the parity packet (21 more words). tlast marks
// each packet's final word, which carries 4 valid bytes; tuser flags parity and the
// last word caused by the input transfer.
// Throughput: one output word per cycle while the receiver keeps pace, set by the single
// read port of each buffer memory; input is held off after a kept datagram while its
// forwarded packet and any parity packet are read from the buffers.
// A stalled receiver holds the output word; a two-word output register and skid stage
// stop further buffer reads until space frees up, so nothing is lost.
// Reset clears the pair state, the word count and the output stage; buffer contents
// are undefined until written and need no clearing pass.
module pairwise_xor_parity_fec_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [63:0] word_data, [67:64] word_bytes, [71:68] zero
  input  logic        s_axis_tlast,   // datagram_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] out_data, [67:64] out_bytes, [71:68] zero
  output logic [1:0]  m_axis_tuser,   // [0] is_parity, [1] run_last
  output logic        m_axis_tlast    // packet_end
);

  logic                           cur_we;
  logic [pxfec_pkg::ADDR_W-1:0]   cur_waddr;
  logic [63:0]                    cur_wdata;
  pxfec_pkg::rd_req_t             rd_req;
  logic                           issue_ok;
  logic                           ret_valid;
  pxfec_pkg::rd_tag_t             ret_tag;
  logic [31:0]                    par_seq;
  logic [63:0]                    cur_rdata;
  logic [63:0]                    sto_rdata;
  pxfec_pkg::res_t                out_res;

  pxfec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata[63:0]),
    .in_bytes_i  (s_axis_tdata[67:64]),
    .in_end_i    (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .cur_we_o    (cur_we),
    .cur_waddr_o (cur_waddr),
    .cur_wdata_o (cur_wdata),
    .rd_req_o    (rd_req),
    .issue_ok_i  (issue_ok),
    .ret_valid_o (ret_valid),
    .ret_tag_o   (ret_tag),
    .par_seq_o   (par_seq)
  );

  pxfec_buf u_buf (
    .clk_i       (clk_i),
    .cur_we_i    (cur_we),
    .cur_waddr_i (cur_waddr),
    .cur_wdata_i (cur_wdata),
    .rd_req_i    (rd_req),
    .ret_valid_i (ret_valid),
    .ret_tag_i   (ret_tag),
    .cur_rdata_o (cur_rdata),
    .sto_rdata_o (sto_rdata)
  );

  pxfec_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ret_valid_i (ret_valid),
    .ret_tag_i   (ret_tag),
    .cur_rdata_i (cur_rdata),
    .sto_rdata_i (sto_rdata),
    .par_seq_i   (par_seq),
    .out_ready_i (m_axis_tready),
    .issue_ok_o  (issue_ok),
    .out_res_o   (out_res),
    .out_valid_o (m_axis_tvalid)
  );

  // Pack the output transfer
  assign m_axis_tdata = {4'd0, out_res.nbytes, out_res.data};
  assign m_axis_tuser = {out_res.run_last, out_res.par};
  assign m_axis_tlast = out_res.pend;

  // Never read the buffer while input may write it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req.en |-> !s_axis_tready)
    else $error("buffer read issued while input is accepted");

  // A run ends only on a packet's final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
    else $error("run end without packet end");

  // Final packet word carries the short byte count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[67:64] == pxfec_pkg::LAST_CNT))
    else $error("wrong byte count on final packet word");

  // Every read returns data in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req.en |=> ret_valid)
    else $error("buffer read did not return");

endmodule

FILE: test/tb_pairwise_xor_parity_fec_encoder_top.sv
`timescale 1ns / 1ps

module tb_pairwise_xor_parity_fec_encoder_top;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned WORD_GOAL  = 360;

  // Fill patterns for datagram words
  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_e;

  // Predicts forwarded and parity words and checks them in order
  class fec_word_checker;
    logic [7:0]  frame_buf  [pxfec_pkg::PKT_BYTES];
    logic [7:0]  parity_buf [pxfec_pkg::PKT_BYTES];
    logic [7:0]  first_half [pxfec_pkg::PAYLOAD_BYTES];
    logic [31:0] first_seq;
    bit          pair_pending;
    int unsigned fill;
    pxfec_pkg::res_t pending_words[$];
    int unsigned errors, words_in, kept, dropped, parity_pkts, checked;

    function new();
      first_seq    = '0;
      pair_pending = 1'b0;
      fill         = 0;
    endfunction

    // Queue one outgoing packet from the frame or the parity buffer
    function void push_packet(bit parity, bit closes);
      pxfec_pkg::res_t r;
      int unsigned     w, b, idx;
      for (w = 0; w < pxfec_pkg::PKT_WORDS; w++) begin
        r = '0;
        for (b = 0; b < 8; b++) begin
          idx = w * 8 + b;
          r.data = r.data << 8;
          if (idx < pxfec_pkg::PKT_BYTES) begin
            r.data[7:0] = parity ? parity_buf[idx] : frame_buf[idx];
            r.nbytes++;
          end
        end
        r.par      = parity;
        r.pend     = (w == pxfec_pkg::PKT_WORDS - 1);
        r.run_last = closes && (w == pxfec_pkg::PKT_WORDS - 1);
        pending_words.push_back(r);
      end
    endfunction

    // Note one accepted datagram word
    function void take_word(logic [63:0] data, logic [3:0] nb_in, logic last);
      int unsigned nb, i;
      logic [31:0] seq, ps;
      bit          mate;
      words_in++;
      nb = (!last || nb_in > 8) ? 8 : nb_in;
      for (i = 0; i < nb; i++) begin
        if (fill < pxfec_pkg::PKT_BYTES) begin
          frame_buf[fill] = data[63 - 8 * i -: 8];
          fill++;
        end
      end
      if (!last) return;
      if (fill >= pxfec_pkg::PKT_BYTES) begin
        kept++;
        seq  = {frame_buf[0], frame_buf[1], frame_buf[2], frame_buf[3]};
        mate = seq[0] && pair_pending && (seq == first_seq + 32'd1);
        push_packet(1'b0, !mate);
        if (!seq[0]) begin
          // hold the payload as the first half of a pair
          for (i = 0; i < pxfec_pkg::PAYLOAD_BYTES; i++) first_half[i] = frame_buf[4 + i];
          first_seq    = seq;
          pair_pending = 1'b1;
        end else if (mate) begin
          ps = first_seq | pxfec_pkg::PARITY_FLAG;
          {parity_buf[0], parity_buf[1], parity_buf[2], parity_buf[3]} = ps;
          for (i = 0; i < pxfec_pkg::PAYLOAD_BYTES; i++)
            parity_buf[4 + i] = first_half[i] ^ frame_buf[4 + i];
          push_packet(1'b1, 1'b1);
          parity_pkts++;
          pair_pending = 1'b0;
        end
      end else begin
        dropped++;
      end
      fill = 0;
    endfunction

    function void compare(string what, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
      end
    endfunction

    // Check one accepted output transfer against the oldest expectation
    function void check_out_word(logic [71:0] tdata, logic [1:0] tuser, logic tlast);
      pxfec_pkg::res_t e;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected word, expected none, actual %h", $time, tdata);
        return;
      end
      e = pending_words.pop_front();
      checked++;
      compare("out_data",   e.data,             tdata[63:0]);
      compare("out_bytes",  64'(e.nbytes),      64'(tdata[67:64]));
      compare("pad bits",   64'd0,              64'(tdata[71:68]));
      compare("is_parity",  64'(e.par),         64'(tuser[0]));
      compare("run_last",   64'(e.run_last),    64'(tuser[1]));
      compare("packet_end", 64'(e.pend),        64'(tlast));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  fec_word_checker sb;
  int unsigned     burst_left;
  int unsigned     words_sent;
  int unsigned     idle_cycles;
  int unsigned     rx_cycle;
  int unsigned     rx_mode;
  int unsigned     stall_left;

  pairwise_xor_parity_fec_encoder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sample both sides at the rising edge; outputs first, then the input transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_out_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        sb.take_word(s_axis_tdata[63:0], s_axis_tdata[67:64], s_axis_tlast);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver backpressure: switch between stall styles every so often
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = 1'($urandom_range(0, 1));
      2: m_axis_tready = ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left > 0) begin
          m_axis_tready = 1'b0;
          stall_left--;
        end else begin
          m_axis_tready = 1'b1;
          if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 20);
        end
      end
    endcase
  end

  // Drive one word at the falling edge, after any random gap, and hold it until the transfer
  task automatic drive_word(logic [63:0] data, logic [3:0] nb, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'd0, nb, data};
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic send_datagram(logic [31:0] seq, int unsigned nwords, logic [3:0] last_bytes,
                               fill_e fill_kind);
    int unsigned k;
    logic [63:0] w;
    logic [3:0]  nb;
    for (k = 0; k < nwords; k++) begin
      case (fill_kind)
        FILL_ZEROS: w = '0;
        FILL_ONES:  w = '1;
        default:    w = {$urandom, $urandom};
      endcase
      if (k == 0) w[63:32] = seq;
      nb = (k == nwords - 1) ? last_bytes : 4'($urandom_range(0, 15));
      drive_word(w, nb, k == nwords - 1);
    end
  endtask

  // Stop sending until every predicted word has come out
  task automatic drain_outputs();
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (sb.pending_words.size() != 0) @(negedge clk_i);
  endtask

  // Random datagram: mostly well-formed pairs, some mismatches, short and long ones
  task automatic send_random_datagram();
    int unsigned r, len_pick, nwords;
    logic [31:0] seq;
    logic [3:0]  last_bytes;
    fill_e       fill_kind;
    r = $urandom_range(0, 99);
    if (sb.pair_pending && r < 55)      seq = sb.first_seq + 32'd1;
    else if (r < 80)                    seq = {$urandom} & ~32'd1;
    else if (sb.pair_pending && r < 90) seq = sb.first_seq + 32'd3;
    else                                seq = {$urandom} | 32'd1;
    len_pick = $urandom_range(0, 99);
    if (len_pick < 75) begin
      nwords = pxfec_pkg::PKT_WORDS;
      last_bytes = 4'($urandom_range(4, 15));
    end else if (len_pick < 87) begin
      nwords = $urandom_range(pxfec_pkg::PKT_WORDS + 1, pxfec_pkg::PKT_WORDS + 3);
      last_bytes = 4'($urandom_range(0, 15));
    end else if (len_pick < 93) begin
      nwords = pxfec_pkg::PKT_WORDS;
      last_bytes = 4'($urandom_range(0, 3));
    end else begin
      nwords = $urandom_range(1, pxfec_pkg::PKT_WORDS - 1);
      last_bytes = 4'($urandom_range(0, 15));
    end
    r = $urandom_range(0, 9);
    fill_kind = (r == 0) ? FILL_ZEROS : (r == 1) ? FILL_ONES : FILL_RANDOM;
    send_datagram(seq, nwords, last_bytes, fill_kind);
  endtask

  initial begin
    bit paused;
    sb         = new();
    burst_left = 0;
    words_sent = 0;
    idle_cycles = 0;
    rx_cycle   = 0;
    rx_mode    = 0;
    stall_left = 0;
    paused     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty final word, oversized count on a lone word, minimal even
    // datagram with the top sequence bit already set
    send_datagram(32'hFFFF_FFFF, 1, 4'd0, FILL_ONES);
    send_datagram(32'h0000_0000, 1, 4'd15, FILL_ZEROS);
    send_datagram(32'hFFFF_FFFE, pxfec_pkg::PKT_WORDS, 4'd4, FILL_ONES);
    drain_outputs();

    // Random traffic, with one full pause halfway
    while (words_sent < WORD_GOAL) begin
      send_random_datagram();
      if (!paused && words_sent >= WORD_GOAL / 2) begin
        drain_outputs();
        paused = 1'b1;
      end
    end

    drain_outputs();
    repeat (20) @(negedge clk_i);

    $display("summary: %0d input words, %0d datagrams kept, %0d dropped, %0d parity packets",
             sb.words_in, sb.kept, sb.dropped, sb.parity_pkts);
    $display("summary: %0d output words checked, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/pxfec_pkg.sv
src/pxfec_buf.sv
src/pxfec_ctrl.sv
src/pxfec_out.sv
src/pairwise_xor_parity_fec_encoder_top.sv
test/tb_pairwise_xor_parity_fec_encoder_top.sv
